// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_TX_SETUP  = 4'd3,
    PH_TX_HIGH   = 4'd4,
    PH_TX_LOW    = 4'd5,
    PH_ACK_SETUP = 4'd6,
    PH_ACK_HIGH  = 4'd7,
    PH_ACK_POLL  = 4'd8,
    PH_RX_LOW    = 4'd9,
    PH_RX_HIGH   = 4'd10,
    PH_MACK_LOW  = 4'd11,
    PH_MACK_HIGH = 4'd12,
    PH_STOP_LOW  = 4'd13,
    PH_STOP_HIGH = 4'd14,
    PH_HOLDOFF   = 4'd15
  } phase_t;

  // Request operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Byte step within a transaction
  localparam logic [1:0] STEP_ADDR = 2'd0;
  localparam logic [1:0] STEP_REG  = 2'd1;
  localparam logic [1:0] STEP_DATA = 2'd2;
  localparam logic [1:0] STEP_RX   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_US  = 2'd0;
  localparam logic [1:0] CFG_ACK_POLL_LIM  = 2'd1;
  localparam logic [1:0] CFG_WR_HOLDOFF_US = 2'd2;

  localparam logic [9:0]  TICKS_PER_US_RST  = 10'd168;
  localparam logic [7:0]  ACK_POLL_LIM_RST  = 8'd250;
  localparam logic [15:0] WR_HOLDOFF_US_RST = 16'd10000;

  localparam int DLY_W = 27;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic [7:0] read_count;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        sda_drive_en;
    logic        busy_res;
    logic [7:0]  rd_data;
    logic        rd_valid;
    logic        rd_last;
    logic        done_res;
    logic        nack_error;
    logic [31:0] error_count;
  } res_t;

  // Phase durations in ticks, already clamped to at least one
  typedef struct packed {
    logic [7:0]       ack_limit;
    logic [DLY_W-1:0] t4;
    logic [DLY_W-1:0] t2;
    logic [DLY_W-1:0] t1;
    logic [DLY_W-1:0] thold;
  } cfg_t;

endpackage

// ===== rtl/i2c_master_register_access_unit.sv =====
// I2C master for single-register writes and multi-byte register reads.
// Each input transaction is one bus tick: it carries a request code
// (tick only, register write, register read), the request fields and the
// sampled SDA level. Each input transaction produces exactly one output
// transaction with the SCL/SDA levels to drive for that tick, read bytes,
// done/abort flags and the running abort count.
// A request is taken only while the bus is idle; requests while busy are
// ignored. Ack polling aborts after ack_poll_limit + 1 high samples and sends STOP.
// The input transaction is registered, then the sequencer step writes the
// output register, which drives the output transaction.
// Throughput: one transaction per cycle while the output is not stalled; the
// sequencer state update is the loop that sets this.
// Reset (synchronous, rst_n low) returns the sequencer to idle, clears the
// abort count and loads the configuration defaults.
// When out_stall is high the finished output waits in its register; the
// input register still takes one more transaction, then in_stall rises until
// the output moves on. The user must write configuration only while idle; the block does not check this.
module i2c_master_register_access_unit
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [6:0]  in_dev_addr,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_wr_data,
  input  logic [7:0]  in_read_count,
  input  logic        in_sda_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_sda_drive_en,
  output logic        out_busy_res,
  output logic [7:0]  out_rd_data,
  output logic        out_rd_valid,
  output logic        out_rd_last,
  output logic        out_done_res,
  output logic        out_nack_error,
  output logic [31:0] out_error_count
);

  cfg_t     cfg;
  in_item_t in_item_r;
  logic     in_vld_r;
  res_t     seq_res;
  res_t     out_r;
  logic     out_vld_r;
  logic     in_acc;
  logic     adv;

  // Sequencer steps when an item is held and the output register is free
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.operation  <= in_operation;
      in_item_r.dev_addr   <= in_dev_addr;
      in_item_r.reg_addr   <= in_reg_addr;
      in_item_r.wr_data    <= in_wr_data;
      in_item_r.read_count <= in_read_count;
      in_item_r.sda_in     <= in_sda_in;
    end
  end

  i2cm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  i2cm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (seq_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= seq_res;
  end

  assign out_valid        = out_vld_r;
  assign out_scl_out      = out_r.scl_out;
  assign out_sda_out      = out_r.sda_out;
  assign out_sda_drive_en = out_r.sda_drive_en;
  assign out_busy_res     = out_r.busy_res;
  assign out_rd_data      = out_r.rd_data;
  assign out_rd_valid     = out_r.rd_valid;
  assign out_rd_last      = out_r.rd_last;
  assign out_done_res     = out_r.done_res;
  assign out_nack_error   = out_r.nack_error;
  assign out_error_count  = out_r.error_count;

  // A finished transaction never shows a byte at the same tick
  a_done_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_rd_valid && !out_busy_res)
    else $error("done together with read byte or busy");

  a_nack_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nack_error |-> out_done_res)
    else $error("abort flag without done");

  // Released SDA reads back as high
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sda_drive_en |-> out_sda_out)
    else $error("SDA low while released");

  // A full output register with stall holds the input side back
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall && in_vld_r |-> in_stall)
    else $error("sequencer stepped into a stalled output");

endmodule

// ===== rtl/i2cm_cfg.sv =====
module i2cm_cfg
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data,
  output cfg_t        cfg
);

  logic [9:0]       tpu_r;
  logic [7:0]       ack_lim_r;
  logic [15:0]      hold_us_r;
  logic [DLY_W-1:0] t4_r, t2_r, t1_r, thold_r;
  logic [DLY_W-1:0] t4_nxt, t2_nxt, t1_nxt, thold_nxt;
  logic [25:0]      hold_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r     <= TICKS_PER_US_RST;
      ack_lim_r <= ACK_POLL_LIM_RST;
      hold_us_r <= WR_HOLDOFF_US_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TICKS_PER_US:  tpu_r     <= cfg_wr_data[9:0];
        CFG_ACK_POLL_LIM:  ack_lim_r <= cfg_wr_data[7:0];
        CFG_WR_HOLDOFF_US: hold_us_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Durations follow config in the next cycle; the user must change config only while idle (not enforced).
  assign hold_prod = 26'(hold_us_r) * 26'(tpu_r);

  always_comb begin
    t1_nxt    = {{(DLY_W-10){1'b0}}, tpu_r};
    t2_nxt    = {{(DLY_W-11){1'b0}}, tpu_r, 1'b0};
    t4_nxt    = {{(DLY_W-12){1'b0}}, tpu_r, 2'b00};
    thold_nxt = {{(DLY_W-26){1'b0}}, hold_prod};
    if (tpu_r == '0) begin
      t1_nxt = DLY_W'(1);
      t2_nxt = DLY_W'(1);
      t4_nxt = DLY_W'(1);
    end
    if (hold_prod == '0) thold_nxt = DLY_W'(1);
  end

  always_ff @(posedge clk) begin
    t4_r    <= t4_nxt;
    t2_r    <= t2_nxt;
    t1_r    <= t1_nxt;
    thold_r <= thold_nxt;
  end

  assign cfg.ack_limit = ack_lim_r;
  assign cfg.t4        = t4_r;
  assign cfg.t2        = t2_r;
  assign cfg.t1        = t1_r;
  assign cfg.thold     = thold_r;

endmodule

// ===== rtl/i2cm_seq.sv =====
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  input  cfg_t     cfg,
  output res_t     res
);

  phase_t           phase_r, phase_nxt;
  logic [2:0]       bit_idx_r, bit_idx_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       bytes_left_r, bytes_left_nxt;
  logic [DLY_W-1:0] dly_r, dly_nxt;
  logic [7:0]       polls_r, polls_nxt;
  logic [6:0]       dev_r, dev_nxt;
  logic             rd_flag_r, rd_flag_nxt;
  logic [7:0]       reg_r, reg_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [1:0]       stp_r, stp_nxt;
  logic             abort_r, abort_nxt;
  logic [31:0]      abort_total_r, abort_total_nxt;
  logic             last;

  function automatic logic [DLY_W-1:0] ticks_for(phase_t p, cfg_t c);
    logic [DLY_W-1:0] t;
    t = DLY_W'(1);
    case (p) inside
      PH_START_A, PH_START_B, PH_STOP_LOW, PH_STOP_HIGH: t = c.t4;
      PH_TX_SETUP, PH_TX_HIGH, PH_TX_LOW, PH_RX_LOW,
      PH_MACK_LOW, PH_MACK_HIGH:                         t = c.t2;
      PH_ACK_SETUP, PH_ACK_HIGH, PH_RX_HIGH:             t = c.t1;
      PH_HOLDOFF:                                        t = c.thold;
      default:                                           t = DLY_W'(1);
    endcase
    return t;
  endfunction

  always_comb begin
    phase_nxt       = phase_r;
    bit_idx_nxt     = bit_idx_r;
    shift_nxt       = shift_r;
    bytes_left_nxt  = bytes_left_r;
    dly_nxt         = dly_r;
    polls_nxt       = polls_r;
    dev_nxt         = dev_r;
    rd_flag_nxt     = rd_flag_r;
    reg_nxt         = reg_r;
    data_nxt        = data_r;
    stp_nxt         = stp_r;
    abort_nxt       = abort_r;
    abort_total_nxt = abort_total_r;
    res             = '0;
    res.scl_out      = 1'b1;
    res.sda_out      = 1'b1;
    res.sda_drive_en = 1'b1;
    last = (bytes_left_r <= 8'd1);

    // Latch a new request; its first bus tick is this one
    if (phase_r == PH_IDLE &&
        (item.operation == OP_WRITE || item.operation == OP_READ)) begin
      dev_nxt        = item.dev_addr;
      rd_flag_nxt    = (item.operation == OP_READ);
      reg_nxt        = item.reg_addr;
      data_nxt       = item.wr_data;
      stp_nxt        = STEP_ADDR;
      abort_nxt      = 1'b0;
      bytes_left_nxt = (item.read_count == '0) ? 8'd1 : item.read_count;
      last           = (bytes_left_nxt <= 8'd1);
      polls_nxt      = '0;
      bit_idx_nxt    = '0;
      shift_nxt      = '0;
      phase_nxt      = PH_START_A;
      dly_nxt        = ticks_for(PH_START_A, cfg);
    end

    // Line levels
    case (phase_nxt)
      PH_START_B: res.sda_out = 1'b0;
      PH_TX_SETUP, PH_TX_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = shift_nxt[7];
      end
      PH_TX_HIGH: res.sda_out = shift_nxt[7];
      PH_ACK_SETUP, PH_RX_LOW: begin
        res.scl_out      = 1'b0;
        res.sda_drive_en = 1'b0;
      end
      PH_ACK_HIGH, PH_ACK_POLL, PH_RX_HIGH: res.sda_drive_en = 1'b0;
      PH_MACK_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = last;
      end
      PH_MACK_HIGH: res.sda_out = last;
      PH_STOP_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = 1'b0;
      end
      default: ;
    endcase

    if (phase_nxt == PH_ACK_POLL) begin
      if (!item.sda_in) begin
        // slave acked: move to the next byte step
        unique case (stp_nxt)
          STEP_ADDR: begin
            stp_nxt     = STEP_REG;
            shift_nxt   = reg_nxt;
            bit_idx_nxt = '0;
            phase_nxt   = PH_TX_SETUP;
          end
          STEP_REG: begin
            if (rd_flag_nxt) begin
              stp_nxt   = STEP_RX;
              phase_nxt = PH_START_A;
            end else begin
              stp_nxt     = STEP_DATA;
              shift_nxt   = data_nxt;
              bit_idx_nxt = '0;
              phase_nxt   = PH_TX_SETUP;
            end
          end
          STEP_RX: begin
            bit_idx_nxt = '0;
            shift_nxt   = '0;
            phase_nxt   = PH_RX_LOW;
          end
          default: phase_nxt = PH_STOP_LOW;
        endcase
        dly_nxt = ticks_for(phase_nxt, cfg);
      end else if (polls_nxt >= cfg.ack_limit) begin
        abort_nxt = 1'b1;
        phase_nxt = PH_STOP_LOW;
        dly_nxt   = ticks_for(PH_STOP_LOW, cfg);
      end else begin
        polls_nxt = polls_nxt + 8'd1;
      end
    end else if (phase_nxt != PH_IDLE) begin
      if (dly_nxt != '0) dly_nxt = dly_nxt - DLY_W'(1);
      if (dly_nxt == '0) begin
        unique case (phase_nxt)
          PH_START_A: phase_nxt = PH_START_B;
          PH_START_B: begin
            shift_nxt   = {dev_nxt, (stp_nxt == STEP_RX)};
            bit_idx_nxt = '0;
            phase_nxt   = PH_TX_SETUP;
          end
          PH_TX_SETUP: phase_nxt = PH_TX_HIGH;
          PH_TX_HIGH:  phase_nxt = PH_TX_LOW;
          PH_TX_LOW: begin
            shift_nxt = {shift_nxt[6:0], 1'b0};
            if (bit_idx_nxt == 3'd7) begin
              polls_nxt = '0;
              phase_nxt = PH_ACK_SETUP;
            end else begin
              bit_idx_nxt = bit_idx_nxt + 3'd1;
              phase_nxt   = PH_TX_SETUP;
            end
          end
          PH_ACK_SETUP: phase_nxt = PH_ACK_HIGH;
          PH_ACK_HIGH:  phase_nxt = PH_ACK_POLL;
          PH_RX_LOW:    phase_nxt = PH_RX_HIGH;
          PH_RX_HIGH: begin
            // sample on the last tick of SCL high
            shift_nxt = {shift_nxt[6:0], item.sda_in};
            if (bit_idx_nxt == 3'd7) begin
              res.rd_valid = 1'b1;
              res.rd_data  = shift_nxt;
              res.rd_last  = last;
              phase_nxt    = PH_MACK_LOW;
            end else begin
              bit_idx_nxt = bit_idx_nxt + 3'd1;
              phase_nxt   = PH_RX_LOW;
            end
          end
          PH_MACK_LOW: phase_nxt = PH_MACK_HIGH;
          PH_MACK_HIGH: begin
            if (last) begin
              phase_nxt = PH_STOP_LOW;
            end else begin
              bytes_left_nxt = bytes_left_nxt - 8'd1;
              bit_idx_nxt    = '0;
              shift_nxt      = '0;
              phase_nxt      = PH_RX_LOW;
            end
          end
          PH_STOP_LOW: phase_nxt = PH_STOP_HIGH;
          PH_STOP_HIGH: begin
            if (abort_nxt) begin
              abort_total_nxt = abort_total_nxt + 32'd1;
              res.nack_error  = 1'b1;
              res.done_res    = 1'b1;
              phase_nxt       = PH_IDLE;
            end else if (!rd_flag_nxt) begin
              phase_nxt = PH_HOLDOFF;
            end else begin
              res.done_res = 1'b1;
              phase_nxt    = PH_IDLE;
            end
          end
          PH_HOLDOFF: begin
            res.done_res = 1'b1;
            phase_nxt    = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
        // ack poll phase runs untimed
        dly_nxt = (phase_nxt == PH_ACK_POLL) ? '0 : ticks_for(phase_nxt, cfg);
      end
    end
    if (phase_nxt == PH_IDLE) dly_nxt = '0;

    res.busy_res    = (phase_nxt != PH_IDLE);
    res.error_count = abort_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_idx_r     <= '0;
      shift_r       <= '0;
      bytes_left_r  <= '0;
      dly_r         <= '0;
      polls_r       <= '0;
      dev_r         <= '0;
      rd_flag_r     <= 1'b0;
      reg_r         <= '0;
      data_r        <= '0;
      stp_r         <= STEP_ADDR;
      abort_r       <= 1'b0;
      abort_total_r <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bit_idx_r     <= bit_idx_nxt;
      shift_r       <= shift_nxt;
      bytes_left_r  <= bytes_left_nxt;
      dly_r         <= dly_nxt;
      polls_r       <= polls_nxt;
      dev_r         <= dev_nxt;
      rd_flag_r     <= rd_flag_nxt;
      reg_r         <= reg_nxt;
      data_r        <= data_nxt;
      stp_r         <= stp_nxt;
      abort_r       <= abort_nxt;
      abort_total_r <= abort_total_nxt;
    end
  end

endmodule
